/* design/cpt_pkg.sv */
// Shared types and constants for the color palette table.
`timescale 1ns / 1ps
package cpt_pkg;
  localparam int DEF_DEPTH = 256;
  localparam logic [3:0] SIG_BITS_RESET = 4'd8;
  localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;
  localparam logic [17:0] DIST_MAX = 18'h3ffff;
  localparam int ENT_W = 56;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_LOOK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS,
    S_SHIFT,
    S_LOOK,
    S_READ,
    S_READW,
    S_DONE
  } state_t;
endpackage

/* design/color_palette_table_core.sv */
// Top level of the color palette table: sorted color store, add, lookup, read.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | op, red, green, blue, index
//  out_    | output    | out_valid/out_stall | status, entry_index, colors, counts
//  cfg_    | input     | cfg_we              | significant_bits
//
// An add scans to its slot, then for a new color shifts the entries above it;
// a lookup scans all entries and a read one: one RAM read port sets the pace.
// rst_n clears the entry count, state and output valid; no clearing pass.
// A finished beat waits in the output register while out_stall is high; the
// next input beat is taken as soon as the sequencer is idle.
`timescale 1ns / 1ps
module color_palette_table_core #(
  parameter int PALETTE_DEPTH = cpt_pkg::DEF_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_significant_bits,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_entry_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [31:0] out_occurrences,
  output logic [8:0]  out_entries_used
);
  import cpt_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [3:0]        sig_r;
  logic [23:0]       col_r, col_nxt;
  logic [7:0]        idx_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              pv_r, pv_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic              s1v_r, s1v_nxt;
  logic [AW-1:0]     s1idx_r;
  logic [ENT_W-1:0]  s1ent_r;
  logic [15:0]       sqr_r, sqg_r, sqb_r;
  logic [17:0]       best_r, best_nxt;
  logic [AW-1:0]     bidx_r, bidx_nxt;
  logic [ENT_W-1:0]  bent_r, bent_nxt;
  logic [1:0]        rst_st_r, rst_st_nxt;
  logic [AW-1:0]     ridx_r, ridx_nxt;
  logic [ENT_W-1:0]  rent_r, rent_nxt;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic              in_acc, out_load;
  logic [3:0]        bits;
  logic [7:0]        mask;
  logic [23:0]       mcol;
  logic [17:0]       dsum;
  logic signed [8:0] dr, dg, db;
  logic              ptr_more, pos_more;

  cpt_ram #(.WIDTH(ENT_W), .DEPTH(PALETTE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid || !out_stall);
  assign ptr_more = (ptr_r < cnt_r);
  assign pos_more = (ptr_r > pos_r);

  assign bits = (sig_r > 4'd8) ? 4'd8 : sig_r;
  assign mask = 8'(8'hff << (4'd8 - bits));
  assign mcol = {in_red & mask, in_green & mask, in_blue & mask};

  assign dr = $signed({1'b0, col_r[23:16]}) - $signed({1'b0, ram_rdata[55:48]});
  assign dg = $signed({1'b0, col_r[15:8]})  - $signed({1'b0, ram_rdata[47:40]});
  assign db = $signed({1'b0, col_r[7:0]})   - $signed({1'b0, ram_rdata[39:32]});
  assign dsum = 18'(sqr_r) + 18'(sqg_r) + 18'(sqb_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_op))
            OP_ADD:  state_nxt = S_SCAN;
            OP_LOOK: state_nxt = S_LOOK;
            OP_READ: state_nxt = S_READ;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (pv_r && ram_rdata[55:32] == col_r) begin
          state_nxt = S_DONE;
        end else if (pv_r && ram_rdata[55:32] > col_r) begin
          state_nxt = S_INS;
        end else if (!pv_r && !ptr_more) begin
          state_nxt = S_INS;
        end
      end
      S_INS:   state_nxt = (cnt_r == CW'(PALETTE_DEPTH)) ? S_DONE : S_SHIFT;
      S_SHIFT: if (!pv_r && !pos_more) state_nxt = S_DONE;
      S_LOOK:  if (cnt_r == '0 || (!ptr_more && !pv_r && !s1v_r)) state_nxt = S_DONE;
      S_READ:  state_nxt = (CW'(idx_r) < cnt_r && 9'(idx_r) < 9'(cnt_r)) ? S_READW : S_DONE;
      S_READW: state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    pv_nxt     = 1'b0;
    pidx_nxt   = pidx_r;
    s1v_nxt    = 1'b0;
    best_nxt   = best_r;
    bidx_nxt   = bidx_r;
    bent_nxt   = bent_r;
    rst_st_nxt = rst_st_r;
    ridx_nxt   = ridx_r;
    rent_nxt   = rent_r;
    ram_we     = 1'b0;
    ram_waddr  = pidx_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = AW'(ptr_r);
    case (state_r)
      S_IDLE: begin
        ptr_nxt    = '0;
        best_nxt   = DIST_MAX;
        bidx_nxt   = '0;
        bent_nxt   = '0;
        rst_st_nxt = ST_OK;
        ridx_nxt   = '0;
        rent_nxt   = '0;
        if (in_acc) begin
          col_nxt = (op_t'(in_op) == OP_ADD) ? mcol : {in_red, in_green, in_blue};
        end
      end
      S_SCAN: begin
        if (ptr_more) begin
          pv_nxt   = 1'b1;
          pidx_nxt = AW'(ptr_r);
          ptr_nxt  = ptr_r + 1'b1;
        end
        if (pv_r && ram_rdata[55:32] >= col_r) begin
          pv_nxt  = 1'b0;
          pos_nxt = CW'(pidx_r);
          if (ram_rdata[55:32] == col_r) begin
            // Known color: bump its count, saturating.
            ram_we    = 1'b1;
            ram_waddr = pidx_r;
            ram_wdata = {col_r, (ram_rdata[31:0] == COUNT_MAX) ? COUNT_MAX
                                                               : ram_rdata[31:0] + 1'b1};
            ridx_nxt  = pidx_r;
            rent_nxt  = ram_wdata;
          end
        end else if (!pv_r && !ptr_more) begin
          pos_nxt = cnt_r;
        end
      end
      S_INS: begin
        ptr_nxt = cnt_r;
        if (cnt_r == CW'(PALETTE_DEPTH)) begin
          rst_st_nxt = ST_FULL;
        end
      end
      S_SHIFT: begin
        // Move entry up one slot per cycle, from the top toward pos.
        if (pv_r) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_r + 1'b1;
          ram_wdata = ram_rdata;
        end
        if (pos_more) begin
          ram_raddr = AW'(ptr_r - 1'b1);
          pidx_nxt  = AW'(ptr_r - 1'b1);
          ptr_nxt   = ptr_r - 1'b1;
          pv_nxt    = 1'b1;
        end else if (!pv_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pos_r);
          ram_wdata = {col_r, 32'd1};
          cnt_nxt   = cnt_r + 1'b1;
          ridx_nxt  = AW'(pos_r);
          rent_nxt  = ram_wdata;
        end
      end
      S_LOOK: begin
        if (cnt_r == '0) begin
          rst_st_nxt = ST_EMPTY;
        end else begin
          if (ptr_more) begin
            pv_nxt   = 1'b1;
            pidx_nxt = AW'(ptr_r);
            ptr_nxt  = ptr_r + 1'b1;
          end
          s1v_nxt = pv_r;
          if (s1v_r && dsum < best_r) begin
            best_nxt = dsum;
            bidx_nxt = s1idx_r;
            bent_nxt = s1ent_r;
          end
          if (!ptr_more && !pv_r && !s1v_r) begin
            ridx_nxt = (s1v_r && dsum < best_r) ? s1idx_r : bidx_r;
            rent_nxt = (s1v_r && dsum < best_r) ? s1ent_r : bent_r;
          end
        end
      end
      S_READ: begin
        ram_raddr = AW'(idx_r);
        if (!(CW'(idx_r) < cnt_r && 9'(idx_r) < 9'(cnt_r))) begin
          rst_st_nxt = ST_RANGE;
        end
      end
      S_READW: begin
        ridx_nxt = AW'(idx_r);
        rent_nxt = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sig_r     <= SIG_BITS_RESET;
      cnt_r     <= '0;
      pv_r      <= 1'b0;
      s1v_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) sig_r <= cfg_significant_bits;
      cnt_r <= cnt_nxt;
      pv_r  <= pv_nxt;
      s1v_r <= s1v_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r <= in_index;
    end
    col_r    <= col_nxt;
    ptr_r    <= ptr_nxt;
    pos_r    <= pos_nxt;
    pidx_r   <= pidx_nxt;
    best_r   <= best_nxt;
    bidx_r   <= bidx_nxt;
    bent_r   <= bent_nxt;
    rst_st_r <= rst_st_nxt;
    ridx_r   <= ridx_nxt;
    rent_r   <= rent_nxt;
    s1idx_r  <= pidx_r;
    s1ent_r  <= ram_rdata;
    sqr_r    <= 16'(dr * dr);
    sqg_r    <= 16'(dg * dg);
    sqb_r    <= 16'(db * db);
    if (out_load) begin
      out_status       <= rst_st_r;
      out_entry_index  <= 8'(ridx_r);
      out_red          <= rent_r[55:48];
      out_green        <= rent_r[47:40];
      out_blue         <= rent_r[39:32];
      out_occurrences  <= rent_r[31:0];
      out_entries_used <= 9'(cnt_r);
    end
  end
endmodule

/* design/cpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/cpt_checker.sv */
// Port-level checks for the color palette table, bound to the top level.
`timescale 1ns / 1ps
module cpt_checker #(
  parameter int PALETTE_DEPTH = cpt_pkg::DEF_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [7:0]  out_entry_index,
  input logic [8:0]  out_entries_used
);
  import cpt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_entries_used == 9'(PALETTE_DEPTH) && out_entry_index == 8'd0)
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entries_used == 9'd0)
    else $error("empty status with stored colors");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_used <= 9'(PALETTE_DEPTH))
    else $error("entry count beyond depth");
endmodule

bind color_palette_table_core cpt_checker #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_cpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_entry_index  (out_entry_index),
  .out_entries_used (out_entries_used)
);
